// File: sv/ccp_pkg.sv
package ccp_pkg;

  localparam int MAX_REF_LEN_DEF = 4096;

  // Field widths fixed by the interface
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int POS_W       = 17;

  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_EXTEND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_LENGTH = 3'd4;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_M  = 8'h4D;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_X  = 8'h58;
  localparam logic [7:0] CH_I  = 8'h49;

  localparam logic [15:0]      RUN_MAX = 16'hFFFF;
  localparam logic [15:0]      COV_MAX = 16'hFFFF;
  localparam logic [POS_W-1:0] LEN_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [15:0]        cov;
    logic signed [31:0] score;
  } entry_t;

  // Commands from the sequencer to the read totals unit
  typedef struct packed {
    logic               begin_read;
    logic               clr_totals;
    logic               start;
    logic               gap;
    logic               advance;
    logic               pile;
    logic [15:0]        n;
    logic signed [10:0] per_base;
    logic [11:0]        pos;
  } acc_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// File: sv/cigar_coverage_pileup.sv
// Channel  Direction  tdata (lowest bit up)                      tuser / tlast
// in_      slave      position[11:0], cigar_char[19:12]          kind / last_char
// out_     master     read_total, matched_length, position_score, result_kind / -
//                     position_coverage
// cfg_     write      index 0..4, data up to 13 bits             -
//
// Begin, clear and digit words are handled in the idle state; a readout, or a
// digit that ends the read, moves to the result stage, which waits while the
// output register is still full. An operator letter passes the multiply and
// add steps; an M, =, N or X run then reads and writes back each stored position,
// and a letter that ends the read goes on to the result stage for its summary.
// After reset every memory address is swept to zero with in_tready low.
// One result waits in the output register while the next word is taken; after
// a word that yields a result the block waits until that register is free.
module cigar_coverage_pileup
  import ccp_pkg::*;
#(
  parameter int MAX_REF_LEN = MAX_REF_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // position, cigar_char
  input  logic [1:0]             in_tuser,   // kind
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // read_total, matched_length,
                                             // position_score, position_coverage
  output logic                   out_tuser,  // result_kind
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_REF_LEN);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_REF_LEN);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_REF_LEN - 1);

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_MUL, S_ADD, S_RUN, S_EMIT} state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      init_cnt_r, init_cnt_nxt;
  logic [15:0]        run_cnt_r, run_cnt_nxt;
  logic [POS_W-1:0]   p_r, p_nxt;
  logic [POS_W-1:0]   stop_r, stop_nxt;
  logic signed [10:0] per_base_r, per_base_nxt;
  logic               pile_r, pile_nxt;
  logic               last_r, last_nxt;
  logic               is_sum_r, is_sum_nxt;
  logic               oor_r, oor_nxt;
  logic               rv_r, rv_nxt;
  logic [AW-1:0]      wa_r, wa_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic               out_user_r, out_user_nxt;

  logic signed [10:0] match_r, mismatch_r, gap_open_r, gap_extend_r;
  logic [12:0]        ref_len_r;

  logic               in_fire;
  logic [1:0]         in_kind;
  logic [11:0]        in_pos;
  logic [7:0]         in_char;
  logic [POS_W-1:0]   pos_ext;
  logic               pos_oor;
  logic [7:0]         dig_tmp;
  logic               is_digit;
  logic [19:0]        dec_sum;
  logic               op_match, op_mis, op_pile, op_gap;
  logic [POS_W-1:0]   lim;
  logic [17:0]        end_sum;
  logic               emit_load;
  logic               run_re;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  entry_t             mem_wdata, mem_rdata;
  logic signed [33:0] upd_sum;

  acc_cmd_t           acc_cmd;
  logic signed [31:0] score_total;
  logic [POS_W-1:0]   length_total, cur_pos;

  assign in_kind = in_tuser;
  assign in_pos  = in_tdata[11:0];
  assign in_char = in_tdata[19:12];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire = in_tvalid && in_tready;

  always_comb begin
    pos_ext  = {5'b0, in_pos};
    pos_oor  = (pos_ext >= MAX_POS);
    dig_tmp  = in_char - CH_0;
    is_digit = (in_char >= CH_0) && (in_char <= CH_9);
    dec_sum  = {1'b0, run_cnt_r, 3'b000} + {3'b000, run_cnt_r, 1'b0}
             + {16'b0, dig_tmp[3:0]};
    op_match = (in_char == CH_M) || (in_char == CH_EQ);
    op_mis   = (in_char == CH_N) || (in_char == CH_X);
    op_pile  = op_match || op_mis;
    op_gap   = ((in_char == CH_D) || (in_char == CH_I)) && (run_cnt_r != 16'd0);
    lim      = ({4'b0, ref_len_r} < MAX_POS) ? {4'b0, ref_len_r} : MAX_POS;
    end_sum  = {1'b0, cur_pos} + {2'b00, run_cnt_r};
    run_re   = (state_r == S_RUN) && (p_r < stop_r);
    emit_load = (state_r == S_EMIT) && (!out_valid_r || out_tready);
    upd_sum  = {{2{mem_rdata.score[31]}}, mem_rdata.score}
             + {{23{per_base_r[10]}}, per_base_r};
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    run_cnt_nxt   = run_cnt_r;
    p_nxt         = p_r;
    stop_nxt      = stop_r;
    per_base_nxt  = per_base_r;
    pile_nxt      = pile_r;
    last_nxt      = last_r;
    is_sum_nxt    = is_sum_r;
    oor_nxt       = oor_r;
    rv_nxt        = run_re;
    wa_nxt        = p_r[AW-1:0];
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    acc_cmd       = '0;
    acc_cmd.n     = run_cnt_r;
    acc_cmd.pos   = in_pos;
    acc_cmd.per_base = op_match ? match_r : mismatch_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        init_cnt_nxt = init_cnt_r + AW'(1);
        if (init_cnt_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          last_nxt = in_tlast;
          oor_nxt  = pos_oor;
          case (in_kind)
            KIND_BEGIN: begin
              acc_cmd.begin_read = 1'b1;
              run_cnt_nxt = '0;
            end
            KIND_READ: begin
              is_sum_nxt = 1'b0;
              state_nxt  = S_EMIT;
            end
            KIND_CHAR: begin
              is_sum_nxt = 1'b1;
              if (is_digit) begin
                run_cnt_nxt = (dec_sum > {4'b0, RUN_MAX}) ? RUN_MAX : dec_sum[15:0];
                if (in_tlast) begin
                  run_cnt_nxt = '0;
                  state_nxt   = S_EMIT;
                end
              end else begin
                run_cnt_nxt     = '0;
                acc_cmd.start   = op_pile || op_gap;
                acc_cmd.gap     = op_gap;
                acc_cmd.pile    = op_pile;
                acc_cmd.advance = op_pile || (op_gap && in_char == CH_D);
                pile_nxt        = op_pile;
                per_base_nxt    = acc_cmd.per_base;
                p_nxt           = cur_pos;
                stop_nxt = (end_sum < {1'b0, lim}) ? end_sum[POS_W-1:0] : lim;
                state_nxt       = S_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (pile_r) begin
          state_nxt = S_RUN;
        end else if (last_r) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RUN: begin
        if (run_re) begin
          p_nxt = p_r + POS_W'(1);
        end else begin
          // The last write of the run lands in this cycle.
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = !is_sum_r;
          if (is_sum_r) begin
            acc_cmd.clr_totals = 1'b1;
            out_data_nxt = {7'b0, 16'b0, 32'b0, length_total, score_total};
          end else if (oor_r) begin
            out_data_nxt = '0;
          end else begin
            out_data_nxt = {7'b0, mem_rdata.cov, mem_rdata.score, 17'b0, 32'b0};
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory port selection
  always_comb begin
    mem_re    = run_re || (in_fire && in_kind == KIND_READ && !pos_oor);
    mem_raddr = (state_r == S_RUN) ? p_r[AW-1:0] : pos_ext[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = pos_ext[AW-1:0];
    mem_wdata = '0;
    if (state_r == S_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = init_cnt_r;
    end else if (rv_r) begin
      mem_we          = 1'b1;
      mem_waddr       = wa_r;
      mem_wdata.score = sat32(upd_sum);
      mem_wdata.cov   = (mem_rdata.cov == COV_MAX) ? COV_MAX : mem_rdata.cov + 16'd1;
    end else if (in_fire && in_kind == KIND_CLEAR && !pos_oor) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    stop_r       <= stop_nxt;
    per_base_r   <= per_base_nxt;
    pile_r       <= pile_nxt;
    last_r       <= last_nxt;
    is_sum_r     <= is_sum_nxt;
    oor_r        <= oor_nxt;
    wa_r         <= wa_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
    if (!rst_n) begin
      state_r      <= S_INIT;
      init_cnt_r   <= '0;
      run_cnt_r    <= '0;
      rv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      match_r      <= '0;
      mismatch_r   <= '0;
      gap_open_r   <= '0;
      gap_extend_r <= '0;
      ref_len_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      run_cnt_r   <= run_cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MATCH:      match_r      <= cfg_wdata[10:0];
          REG_MISMATCH:   mismatch_r   <= cfg_wdata[10:0];
          REG_GAP_OPEN:   gap_open_r   <= cfg_wdata[10:0];
          REG_GAP_EXTEND: gap_extend_r <= cfg_wdata[10:0];
          REG_REF_LENGTH: ref_len_r    <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  ccp_mem #(
    .DEPTH(MAX_REF_LEN)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ccp_acc u_acc (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (acc_cmd),
    .gap_open     (gap_open_r),
    .gap_extend   (gap_extend_r),
    .score_total  (score_total),
    .length_total (length_total),
    .cur_pos      (cur_pos)
  );

  // No word may be taken while a run write is still outstanding.
  a_no_accept_mid_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !rv_r)
    else $error("input ready while a position write is pending");

  a_readout_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind == KIND_READ) |=> (state_r == S_EMIT && !in_tready))
    else $error("readout did not go straight to the result stage");

  a_readout_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[48:0] == 49'd0))
    else $error("readout word carries summary fields");

endmodule

// File: sv/ccp_mem.sv
module ccp_mem
  import ccp_pkg::*;
#(
  parameter int DEPTH = MAX_REF_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  entry_t                   wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/ccp_acc.sv
module ccp_acc
  import ccp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  acc_cmd_t                 cmd,
  input  logic signed [10:0]       gap_open,
  input  logic signed [10:0]       gap_extend,
  output logic signed [31:0]       score_total,
  output logic [POS_W-1:0]         length_total,
  output logic [POS_W-1:0]         cur_pos
);

  logic signed [31:0] score_r, score_nxt;
  logic [POS_W-1:0]   len_r, len_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               v1_r, v2_r;
  logic signed [10:0] a_r, a_nxt;
  logic [15:0]        b_r, b_nxt;
  logic signed [10:0] add_r, add_nxt;
  logic signed [10:0] add2_r;
  logic signed [27:0] prod_r, prod_nxt;
  logic [17:0]        len_sum, pos_sum;
  logic signed [33:0] total_sum;

  always_comb begin
    len_sum = {1'b0, len_r} + {2'b00, cmd.n};
    pos_sum = {1'b0, pos_r} + {2'b00, cmd.n};
    a_nxt   = cmd.gap ? gap_extend : cmd.per_base;
    b_nxt   = cmd.gap ? cmd.n - 16'd1 : cmd.n;
    add_nxt = cmd.gap ? gap_open : 11'sd0;
    prod_nxt = 28'(a_r) * 28'($signed({1'b0, b_r}));
    total_sum = {{2{score_r[31]}}, score_r} + {{6{prod_r[27]}}, prod_r}
              + {{23{add2_r[10]}}, add2_r};

    score_nxt = score_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    if (v2_r) begin
      score_nxt = sat32(total_sum);
    end
    if (cmd.start && cmd.pile) begin
      len_nxt = (len_sum > {1'b0, LEN_MAX}) ? LEN_MAX : len_sum[POS_W-1:0];
    end
    if (cmd.start && cmd.advance) begin
      pos_nxt = (pos_sum > {1'b0, LEN_MAX}) ? LEN_MAX : pos_sum[POS_W-1:0];
    end
    if (cmd.begin_read) begin
      pos_nxt   = {5'b0, cmd.pos};
      score_nxt = '0;
      len_nxt   = '0;
    end
    if (cmd.clr_totals) begin
      score_nxt = '0;
      len_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      add_r <= add_nxt;
    end
    prod_r <= prod_nxt;
    add2_r <= add_r;
    if (!rst_n) begin
      score_r <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      score_r <= score_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      v1_r    <= cmd.start;
      v2_r    <= v1_r;
    end
  end

  assign score_total  = score_r;
  assign length_total = len_r;
  assign cur_pos      = pos_r;

endmodule
